/* hdl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define MSCH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// check that a condition implies something in the next cycle
`define MSCH_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: check failed");

`endif

/* hdl/msch_pkg.sv */
// types and constants of the multilevel feedback scheduler
`timescale 1ns / 1ps

package msch_pkg;

    localparam int ID_W    = 8;
    localparam int ARR_W   = 23;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 24;
    localparam int LVL_W   = 2;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_LEVEL_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_QUANTUM0    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_QUANTUM1    = 2'd2;
    localparam logic [IDX_W-1:0] CFG_QUANTUM2    = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic               store;
        logic               last;
    } job_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [TIME_W-1:0]  start;
    } job_rec_t;

    typedef struct packed {
        logic [LVL_W-1:0]   last_level;
        logic [BURST_W-1:0] quantum0;
        logic [BURST_W-1:0] quantum1;
        logic [BURST_W-1:0] quantum2;
    } sched_cfg_t;

    typedef struct packed {
        logic [ID_W-1:0]   done_id;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] turnaround_time;
        logic              last_result;
    } result_t;

    typedef enum logic [2:0] {
        BK_LOAD,
        BK_READ,
        BK_DISP,
        BK_RUN,
        BK_EMIT
    } back_state_t;

endpackage

/* hdl/msch_fifo.sv */
// two-word queue between the loader front and the scheduler back
`timescale 1ns / 1ps

module msch_fifo
    import msch_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  job_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output job_entry_t pop_data,
    output logic       empty
);

    job_entry_t  mem [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/msch_front.sv */
// loader front: takes job words and marks which ones fit in the job table
`timescale 1ns / 1ps

module msch_front
    import msch_pkg::*;
#(
    parameter int MAX_JOBS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ID_W-1:0]    job_id,
    input  logic [ARR_W-1:0]   arrival_time,
    input  logic [BURST_W-1:0] burst_time,
    input  logic               last_job,
    output logic               push,
    output job_entry_t         push_data,
    input  logic               full
);

    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb
    begin
        push_data.id      = job_id;
        push_data.arrival = arrival_time;
        push_data.burst   = burst_time;
        push_data.store   = (count_reg < CW'(MAX_JOBS));
        push_data.last    = last_job;
        count_next        = count_reg;
        if (push)
        begin
            if (last_job)
                count_next = '0;
            else if (push_data.store)
                count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

/* hdl/msch_back.sv */
// scheduler back: job table, level passes and result register
`timescale 1ns / 1ps

module msch_back
    import msch_pkg::*;
#(
    parameter int MAX_JOBS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  sched_cfg_t cfg,
    input  logic       empty,
    input  job_entry_t pop_data,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    result
);

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    job_rec_t mem [MAX_JOBS];

    back_state_t        state_reg, state_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      done_reg, done_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [TIME_W-1:0]  tdisp_reg, tdisp_next;
    logic [BURST_W-1:0] slice_reg, slice_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    job_rec_t           rd_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            result_reg, result_next;

    logic               mem_we;
    logic [IW-1:0]      mem_addr;
    job_rec_t           mem_wdata;
    logic [BURST_W-1:0] quantum;
    logic [BURST_W-1:0] rem_new;
    logic [TIME_W-1:0]  tat;
    logic               at_end;
    logic               last_lvl;
    logic               out_free;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_reg <= mem[idx_reg];
    end

    always_comb
    begin
        case (lvl_reg)
            2'd0:    quantum = cfg.quantum0;
            2'd1:    quantum = cfg.quantum1;
            default: quantum = cfg.quantum2;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        lvl_next       = lvl_reg;
        time_next      = time_reg;
        tdisp_next     = tdisp_reg;
        slice_next     = slice_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = idx_reg;
        mem_wdata      = rd_reg;
        last_lvl       = (lvl_reg == cfg.last_level);
        at_end         = ((CW'(idx_reg) + CW'(1)) == cnt_reg);
        out_free       = !out_valid_reg || out_ready;
        rem_new        = rd_reg.remaining - slice_reg;
        tat            = time_reg - {1'b0, rd_reg.arrival};

        case (state_reg)
            BK_LOAD:
            begin
                if (!empty)
                begin
                    pop                 = 1'b1;
                    mem_addr            = cnt_reg[IW-1:0];
                    mem_wdata.id        = pop_data.id;
                    mem_wdata.arrival   = pop_data.arrival;
                    mem_wdata.burst     = pop_data.burst;
                    mem_wdata.remaining = pop_data.burst;
                    mem_wdata.start     = '0;
                    mem_we              = pop_data.store;
                    if (pop_data.store)
                        cnt_next = cnt_reg + CW'(1);
                    if (pop_data.last)
                    begin
                        state_next = BK_READ;
                        idx_next   = '0;
                        lvl_next   = '0;
                        done_next  = '0;
                        time_next  = '0;
                    end
                end
            end
            BK_READ:
            begin
                state_next = BK_DISP;
            end
            BK_DISP:
            begin
                // lower levels hold only jobs that still have work left
                if (lvl_reg != '0 && rd_reg.remaining == '0)
                begin
                    if (at_end)
                    begin
                        if (last_lvl)
                        begin
                            state_next = BK_LOAD;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            state_next = BK_READ;
                            lvl_next   = lvl_reg + LVL_W'(1);
                            idx_next   = '0;
                        end
                    end
                    else
                    begin
                        state_next = BK_READ;
                        idx_next   = idx_reg + IW'(1);
                    end
                end
                else
                begin
                    // an idle clock jumps ahead to the arrival
                    if (time_reg < {1'b0, rd_reg.arrival})
                        tdisp_next = {1'b0, rd_reg.arrival};
                    else
                        tdisp_next = time_reg;
                    if (last_lvl || rd_reg.remaining < quantum)
                        slice_next = rd_reg.remaining;
                    else
                        slice_next = quantum;
                    start_next = (lvl_reg == '0) ? tdisp_next : rd_reg.start;
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                mem_we              = 1'b1;
                mem_wdata.remaining = rem_new;
                mem_wdata.start     = start_reg;
                time_next           = tdisp_reg + {{(TIME_W-BURST_W){1'b0}}, slice_reg};
                if (rem_new == '0)
                    state_next = BK_EMIT;
                else if (at_end)
                begin
                    if (last_lvl)
                    begin
                        state_next = BK_LOAD;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = BK_READ;
                        lvl_next   = lvl_reg + LVL_W'(1);
                        idx_next   = '0;
                    end
                end
                else
                begin
                    state_next = BK_READ;
                    idx_next   = idx_reg + IW'(1);
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    result_next.done_id         = rd_reg.id;
                    result_next.start_time      = start_reg;
                    result_next.finish_time     = time_reg;
                    result_next.turnaround_time = tat;
                    result_next.waiting_time    =
                        tat - {{(TIME_W-BURST_W){1'b0}}, rd_reg.burst};
                    result_next.last_result     = ((done_reg + CW'(1)) == cnt_reg);
                    done_next                   = done_reg + CW'(1);
                    if (result_next.last_result)
                    begin
                        state_next = BK_LOAD;
                        cnt_next   = '0;
                    end
                    else if (at_end)
                    begin
                        if (last_lvl)
                        begin
                            state_next = BK_LOAD;
                            cnt_next   = '0;
                        end
                        else
                        begin
                            state_next = BK_READ;
                            lvl_next   = lvl_reg + LVL_W'(1);
                            idx_next   = '0;
                        end
                    end
                    else
                    begin
                        state_next = BK_READ;
                        idx_next   = idx_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        tdisp_reg  <= tdisp_next;
        slice_reg  <= slice_next;
        start_reg  <= start_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_LOAD;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            done_reg      <= '0;
            lvl_reg       <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            lvl_reg       <= lvl_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hdl/multilevel_feedback_scheduler.sv */
// top level of the multilevel feedback queue scheduler
//
//  channel | direction | handshake             | word
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid / in_ready   | job_id, arrival_time, burst_time, last_job
//  out     | out       | out_valid / out_ready | done_id .. last_result
//
// jobs load one a cycle, while the back end is loading, through a two-word queue into the job table
// after the last job each level pass visits every loaded job: a skipped job passes
// the read and dispatch states, a run slice adds the run state, and a job that
// finishes adds the emit state (one table port); n jobs over L levels run n to n*L slices
// the queue takes up to two of the next set's words while a set runs
// reset clears all control state; the table needs no clearing
`timescale 1ns / 1ps

module multilevel_feedback_scheduler
    import msch_pkg::*;
#(
    parameter int MAX_JOBS   = 32,
    parameter int MAX_LEVELS = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ID_W-1:0]    job_id,
    input  logic [ARR_W-1:0]   arrival_time,
    input  logic [BURST_W-1:0] burst_time,
    input  logic               last_job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ID_W-1:0]    done_id,
    output logic [TIME_W-1:0]  start_time,
    output logic [TIME_W-1:0]  finish_time,
    output logic [TIME_W-1:0]  waiting_time,
    output logic [TIME_W-1:0]  turnaround_time,
    output logic               last_result
);

    logic [2:0]         level_count_reg;
    logic [BURST_W-1:0] quantum0_reg;
    logic [BURST_W-1:0] quantum1_reg;
    logic [BURST_W-1:0] quantum2_reg;
    sched_cfg_t         cfg;
    logic               push;
    job_entry_t         push_data;
    logic               full;
    logic               pop;
    job_entry_t         pop_data;
    logic               empty;
    result_t            result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= 3'd3;
            quantum0_reg    <= 16'd4;
            quantum1_reg    <= 16'd8;
            quantum2_reg    <= 16'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEVEL_COUNT: level_count_reg <= cfg_data[2:0];
                CFG_QUANTUM0:    quantum0_reg    <= cfg_data;
                CFG_QUANTUM1:    quantum1_reg    <= cfg_data;
                CFG_QUANTUM2:    quantum2_reg    <= cfg_data;
                default:         quantum2_reg    <= quantum2_reg;
            endcase
        end
    end

    // clamp the level count and keep the index of the fcfs level
    always_comb
    begin
        cfg.quantum0 = quantum0_reg;
        cfg.quantum1 = quantum1_reg;
        cfg.quantum2 = quantum2_reg;
        if (level_count_reg < 3'd2)
            cfg.last_level = LVL_W'(1);
        else if (int'(level_count_reg) > MAX_LEVELS)
            cfg.last_level = LVL_W'(MAX_LEVELS - 1);
        else
            cfg.last_level = level_count_reg[LVL_W-1:0] - LVL_W'(1);
    end

    msch_front #(
        .MAX_JOBS(MAX_JOBS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .job_id      (job_id),
        .arrival_time(arrival_time),
        .burst_time  (burst_time),
        .last_job    (last_job),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    msch_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty)
    );

    msch_back #(
        .MAX_JOBS(MAX_JOBS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result   (result)
    );

    assign done_id         = result.done_id;
    assign start_time      = result.start_time;
    assign finish_time     = result.finish_time;
    assign waiting_time    = result.waiting_time;
    assign turnaround_time = result.turnaround_time;
    assign last_result     = result.last_result;

endmodule

/* hdl/msch_checker.sv */
// port-level checks for the scheduler, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msch_checker
    import msch_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               in_valid,
    input logic               in_ready,
    input logic [ID_W-1:0]    job_id,
    input logic [ARR_W-1:0]   arrival_time,
    input logic [BURST_W-1:0] burst_time,
    input logic               last_job,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ID_W-1:0]    done_id,
    input logic [TIME_W-1:0]  start_time,
    input logic [TIME_W-1:0]  finish_time,
    input logic [TIME_W-1:0]  waiting_time,
    input logic [TIME_W-1:0]  turnaround_time,
    input logic               last_result
);

    logic [TIME_W-1:0]               burst_back;
    logic [ID_W+4*TIME_W:0]          out_word;
    logic [ID_W+ARR_W+BURST_W:0]     in_word;

    assign burst_back = turnaround_time - waiting_time;
    assign out_word   = {done_id, start_time, finish_time, waiting_time,
                         turnaround_time, last_result};
    assign in_word    = {job_id, arrival_time, burst_time, last_job};

    // a stalled word holds
    `MSCH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
    // a waiting job word holds on the input side
    `MSCH_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_word))
    // turnaround minus waiting gives back a 16-bit burst
    `MSCH_ASSERT(a_burst_fits, out_valid |-> (burst_back[TIME_W-1:BURST_W] == '0))
    // register writes are never held off
    `MSCH_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready)

endmodule

bind multilevel_feedback_scheduler msch_checker u_msch_checker (.*);
